>>> rtl/touch_coordinate_mapper_defines.svh
// ---------------------------------------------------------------------------
// Touch coordinate mapper assertion macros
// Clocked implication checks, gated off while reset is high.
// ---------------------------------------------------------------------------
`ifndef TOUCH_COORDINATE_MAPPER_DEFINES_SVH
`define TOUCH_COORDINATE_MAPPER_DEFINES_SVH

// same-cycle implication
`define TCM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tcm_pkg.sv
// ---------------------------------------------------------------------------
// Touch coordinate mapper package
// Widths, register indices, orientation codes and shared helpers.
// ---------------------------------------------------------------------------
package tcm_pkg;

  localparam int RAW_W       = 13;
  localparam int DIM_W       = 11;
  localparam int QUOT_W      = DIM_W;
  localparam int PROD_W      = RAW_W + DIM_W;
  localparam int LANE_STAGES = 2 + QUOT_W;
  localparam int PIPE_STAGES = LANE_STAGES + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = RAW_W;

  typedef logic [RAW_W-1:0] raw_t;
  typedef logic [DIM_W-1:0] dim_t;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_W     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_H     = 3'd6;

  localparam raw_t CAL_MIN_RST = 13'd0;
  localparam raw_t CAL_MAX_RST = 13'd4095;
  localparam dim_t PANEL_W_RST = 11'd240;
  localparam dim_t PANEL_H_RST = 11'd320;

  typedef enum logic [1:0] {
    ORI_PORTRAIT,
    ORI_LANDSCAPE,
    ORI_INV_PORTRAIT,
    ORI_INV_LANDSCAPE
  } orient_t;

  typedef struct packed {
    raw_t lo;
    raw_t hi;
    dim_t dim;
  } axis_cfg_t;

  // 13-bit sample from the two response bytes
  function automatic raw_t assemble(logic [7:0] hi, logic [7:0] lo);
    return {hi, lo[7:3]};
  endfunction

endpackage

>>> rtl/tcm_ifs.sv
// ---------------------------------------------------------------------------
// Touch coordinate mapper channels
// Valid/ready channels for raw sample beats and screen coordinate beats.
// ---------------------------------------------------------------------------
interface tcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] x_byte_hi;
  logic [7:0] x_byte_lo;
  logic [7:0] y_byte_hi;
  logic [7:0] y_byte_lo;

  modport source (output valid, x_byte_hi, x_byte_lo, y_byte_hi, y_byte_lo,
                  input ready);
  modport sink (input valid, x_byte_hi, x_byte_lo, y_byte_hi, y_byte_lo,
                output ready);
endinterface

interface tcm_out_if #(parameter int COORD_BITS = 11);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] screen_x;
  logic [COORD_BITS-1:0] screen_y;

  modport source (output valid, screen_x, screen_y, input ready);
  modport sink (input valid, screen_x, screen_y, output ready);
endinterface

>>> rtl/tcm_lane.sv
// ---------------------------------------------------------------------------
// Touch coordinate mapper axis lane
// Clamp, multiply by screen dimension, restoring divide by window span
// (one quotient bit per stage) and clamp to dimension minus one; zero for an empty window.
// ---------------------------------------------------------------------------
module tcm_lane (
  input  logic                           clk,
  input  logic [tcm_pkg::LANE_STAGES-1:0] adv,
  input  tcm_pkg::axis_cfg_t             cfg,
  input  logic [7:0]                     byte_hi,
  input  logic [7:0]                     byte_lo,
  output tcm_pkg::dim_t                  mapped
);
  import tcm_pkg::*;

  raw_t              raw;
  raw_t              clamped;
  raw_t              span;
  logic              zero;
  raw_t              diff;
  logic [PROD_W-1:0] rem [QUOT_W+1];
  dim_t              quo [QUOT_W+1];
  logic [PROD_W-1:0] dsh [QUOT_W];
  logic [QUOT_W-1:0] take;
  dim_t              q;

  always_comb begin
    raw = assemble(byte_hi, byte_lo);
    if (raw < cfg.lo) begin
      clamped = cfg.lo;
    end else if (raw > cfg.hi) begin
      clamped = cfg.hi;
    end else begin
      clamped = raw;
    end
    span = cfg.hi - cfg.lo;
    zero = (cfg.hi <= cfg.lo) || (cfg.dim == '0);
    for (int k = 0; k < QUOT_W; k++) begin
      dsh[k]  = PROD_W'(span) << (QUOT_W - 1 - k);
      take[k] = rem[k] >= dsh[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      diff <= clamped - cfg.lo;
    end
    if (adv[1]) begin
      rem[0] <= PROD_W'(diff) * PROD_W'(cfg.dim);
      quo[0] <= '0;
    end
    for (int k = 0; k < QUOT_W; k++) begin
      if (adv[k+2]) begin
        rem[k+1] <= take[k] ? rem[k] - dsh[k] : rem[k];
        quo[k+1] <= {quo[k][QUOT_W-2:0], take[k]};
      end
    end
  end

  always_comb begin
    q = quo[QUOT_W];
    if (zero) begin
      mapped = '0;
    end else if (q >= cfg.dim) begin
      mapped = cfg.dim - DIM_W'(1);
    end else begin
      mapped = q;
    end
  end

endmodule

>>> rtl/tcm_merge.sv
// ---------------------------------------------------------------------------
// Touch coordinate mapper merge stage
// Combines the two lane results by orientation into the output register.
// ---------------------------------------------------------------------------
module tcm_merge #(
  parameter int COORD_BITS = 11
) (
  input  logic                  clk,
  input  logic                  en,
  input  tcm_pkg::orient_t      orientation,
  input  tcm_pkg::dim_t         width,
  input  tcm_pkg::dim_t         height,
  input  tcm_pkg::dim_t         mx,
  input  tcm_pkg::dim_t         my,
  output logic [COORD_BITS-1:0] screen_x,
  output logic [COORD_BITS-1:0] screen_y
);
  import tcm_pkg::*;

  dim_t sx;
  dim_t sy;

  always_comb begin
    case (orientation)
      ORI_PORTRAIT: begin
        sx = my;
        sy = mx;
      end
      ORI_INV_LANDSCAPE: begin
        sx = mx;
        sy = my;
      end
      default: begin
        sx = width - mx;
        sy = height - my;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      screen_x <= COORD_BITS'(sx);
      screen_y <= COORD_BITS'(sy);
    end
  end

endmodule

>>> rtl/touch_coordinate_mapper.sv
// ---------------------------------------------------------------------------
// Touch coordinate mapper
// Path: each accepted sample beat passes clamp and offset, multiply, divide and merge registers.
// Throughput: one beat per cycle while the output is ready; an 11-stage restoring divider,
// one quotient bit per stage, with a lane each for X and Y.
// Reset: calibration and panel registers take their defaults, pipeline empties.
// ---------------------------------------------------------------------------
module touch_coordinate_mapper #(
  parameter int COORD_BITS = 11
) (
  input  logic                           clk,
  input  logic                           rst,
  tcm_in_if.sink                         touch,
  tcm_out_if.source                      coord,
  input  logic                           cfg_we,
  input  logic [tcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcm_pkg::*;
  `include "touch_coordinate_mapper_defines.svh"

  raw_t      cal_x_min;
  raw_t      cal_x_max;
  raw_t      cal_y_min;
  raw_t      cal_y_max;
  orient_t   orientation;
  dim_t      panel_w;
  dim_t      panel_h;

  logic      swap;
  dim_t      width;
  dim_t      height;
  axis_cfg_t cfg_x;
  axis_cfg_t cfg_y;
  dim_t      mx;
  dim_t      my;

  logic [PIPE_STAGES-1:0] v;
  logic [PIPE_STAGES:0]   rdy;
  logic                   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_x_min   <= CAL_MIN_RST;
      cal_x_max   <= CAL_MAX_RST;
      cal_y_min   <= CAL_MIN_RST;
      cal_y_max   <= CAL_MAX_RST;
      orientation <= ORI_PORTRAIT;
      panel_w     <= PANEL_W_RST;
      panel_h     <= PANEL_H_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_X_MIN:   cal_x_min   <= cfg_data;
        REG_CAL_X_MAX:   cal_x_max   <= cfg_data;
        REG_CAL_Y_MIN:   cal_y_min   <= cfg_data;
        REG_CAL_Y_MAX:   cal_y_max   <= cfg_data;
        REG_ORIENTATION: orientation <= orient_t'(cfg_data[1:0]);
        REG_PANEL_W:     panel_w     <= cfg_data[DIM_W-1:0];
        REG_PANEL_H:     panel_h     <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    swap   = (orientation == ORI_LANDSCAPE) || (orientation == ORI_INV_LANDSCAPE);
    width  = swap ? panel_h : panel_w;
    height = swap ? panel_w : panel_h;
    cfg_x  = '{lo: cal_x_min, hi: cal_x_max, dim: width};
    cfg_y  = '{lo: cal_y_min, hi: cal_y_max, dim: height};
  end

  // per-stage ready: a stage moves when empty or its successor moves
  assign rdy[PIPE_STAGES] = coord.ready;
  for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_rdy
    assign rdy[i] = !v[i] || rdy[i+1];
  end

  assign touch.ready = rdy[0] && !rst;
  assign accept      = touch.valid && touch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= accept;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  tcm_lane u_lane_x (
    .clk     (clk),
    .adv     (rdy[LANE_STAGES-1:0]),
    .cfg     (cfg_x),
    .byte_hi (touch.x_byte_hi),
    .byte_lo (touch.x_byte_lo),
    .mapped  (mx)
  );

  tcm_lane u_lane_y (
    .clk     (clk),
    .adv     (rdy[LANE_STAGES-1:0]),
    .cfg     (cfg_y),
    .byte_hi (touch.y_byte_hi),
    .byte_lo (touch.y_byte_lo),
    .mapped  (my)
  );

  tcm_merge #(
    .COORD_BITS (COORD_BITS)
  ) u_merge (
    .clk         (clk),
    .en          (rdy[LANE_STAGES]),
    .orientation (orientation),
    .width       (width),
    .height      (height),
    .mx          (mx),
    .my          (my),
    .screen_x    (coord.screen_x),
    .screen_y    (coord.screen_y)
  );

  assign coord.valid = v[PIPE_STAGES-1];

  `TCM_ASSERT_NEXT(a_accept_fills, clk, rst, accept, v[0], "accepted beat not captured")
  `TCM_ASSERT_IMPL(a_mx_bound, clk, rst, v[LANE_STAGES-1] && (width != '0), mx < width, "X beyond width")
  `TCM_ASSERT_IMPL(a_my_bound, clk, rst, v[LANE_STAGES-1] && (height != '0), my < height, "Y beyond height")

endmodule

>>> bench/touch_coordinate_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Touch coordinate mapper checker
// Tracks the register writes, predicts the screen coordinates of every
// accepted sample beat and compares each coordinate beat, in order, with
// the oldest prediction. Hands the outstanding and failure counts upwards.
// ---------------------------------------------------------------------------
module touch_coordinate_checker #(
  parameter int COORD_BITS = 11
) (
  input  logic                           clk,
  input  logic                           rst,
  tcm_in_if                              touch,
  tcm_out_if                             coord,
  input  logic                           cfg_we,
  input  logic [tcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             outstanding,
  output int                             errors
);
  import tcm_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } screen_pt_t;

  raw_t       x_min, x_max, y_min, y_max;
  orient_t    ori;
  dim_t       pw, ph;
  screen_pt_t expected_pts[$];
  int         reported;

  function automatic dim_t map_axis(input raw_t v, input raw_t lo, input raw_t hi,
                                    input dim_t dim);
    int unsigned pos, span, m;
    if (hi <= lo || dim == 0) begin
      return '0;
    end
    if (v < lo) begin
      v = lo;
    end
    if (v > hi) begin
      v = hi;
    end
    pos  = v - lo;
    span = hi - lo;
    m    = (pos * dim) / span;
    if (m >= dim) begin
      m = dim - 1;
    end
    return dim_t'(m);
  endfunction

  function automatic screen_pt_t predict_point(input logic [7:0] xh, input logic [7:0] xl,
                                               input logic [7:0] yh, input logic [7:0] yl);
    screen_pt_t pt;
    dim_t       wd, ht, mx, my;
    logic       landscape;
    landscape = (ori == ORI_LANDSCAPE) || (ori == ORI_INV_LANDSCAPE);
    wd = landscape ? ph : pw;
    ht = landscape ? pw : ph;
    mx = map_axis({xh, xl[7:3]}, x_min, x_max, wd);
    my = map_axis({yh, yl[7:3]}, y_min, y_max, ht);
    case (ori)
      ORI_PORTRAIT: begin
        pt.x = my;
        pt.y = mx;
      end
      ORI_INV_LANDSCAPE: begin
        pt.x = mx;
        pt.y = my;
      end
      default: begin
        pt.x = wd - mx;
        pt.y = ht - my;
      end
    endcase
    return pt;
  endfunction

  always @(posedge clk) begin
    screen_pt_t want;
    if (rst) begin
      x_min <= CAL_MIN_RST;
      x_max <= CAL_MAX_RST;
      y_min <= CAL_MIN_RST;
      y_max <= CAL_MAX_RST;
      ori   <= ORI_PORTRAIT;
      pw    <= PANEL_W_RST;
      ph    <= PANEL_H_RST;
      expected_pts.delete();
      outstanding <= 0;
      errors      <= 0;
      reported    <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CAL_X_MIN:   x_min <= cfg_data[RAW_W-1:0];
          REG_CAL_X_MAX:   x_max <= cfg_data[RAW_W-1:0];
          REG_CAL_Y_MIN:   y_min <= cfg_data[RAW_W-1:0];
          REG_CAL_Y_MAX:   y_max <= cfg_data[RAW_W-1:0];
          REG_ORIENTATION: ori   <= orient_t'(cfg_data[1:0]);
          REG_PANEL_W:     pw    <= cfg_data[DIM_W-1:0];
          REG_PANEL_H:     ph    <= cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      if (touch.valid && touch.ready) begin
        expected_pts.push_back(predict_point(touch.x_byte_hi, touch.x_byte_lo,
                                             touch.y_byte_hi, touch.y_byte_lo));
      end
      if (coord.valid && coord.ready) begin
        if (expected_pts.size() == 0) begin
          errors <= errors + 1;
          reported <= reported + 1;
          if (reported < 10) begin
            $display("unexpected coord beat: x=%0d y=%0d", coord.screen_x, coord.screen_y);
          end
        end else begin
          want = expected_pts.pop_front();
          if (want.x != coord.screen_x || want.y != coord.screen_y) begin
            errors <= errors + 1;
            reported <= reported + 1;
            if (reported < 10) begin
              $display("coord mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       want.x, want.y, coord.screen_x, coord.screen_y);
            end
          end
        end
      end
      outstanding <= expected_pts.size();
    end
  end

endmodule

>>> bench/tb_touch_coordinate_mapper.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Touch coordinate mapper testbench
// Drives sample beats through directed edge cases and randomised calibration
// phases covering all orientations, with random gaps on both channels and a
// long output hold-off. The checker beside the block scores every beat.
// ---------------------------------------------------------------------------
module tb_touch_coordinate_mapper;
  import tcm_pkg::*;

  localparam int COORD_BITS    = 11;
  localparam int RAND_PHASES   = 16;
  localparam int PHASE_BEATS   = 106;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    raw_t    x_min;
    raw_t    x_max;
    raw_t    y_min;
    raw_t    y_max;
    orient_t ori;
    dim_t    pw;
    dim_t    ph;
  } mapper_cfg_t;

  typedef struct packed {
    logic [7:0] xh;
    logic [7:0] xl;
    logic [7:0] yh;
    logic [7:0] yl;
  } touch_sample_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    outstanding;
  int                    errors;
  int unsigned           cycles;
  bit                    tx_quiet;
  bit                    rx_quiet;
  bit                    hold_req;

  tcm_in_if touch_if ();
  tcm_out_if #(.COORD_BITS(COORD_BITS)) coord_if ();

  touch_coordinate_mapper #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .touch     (touch_if),
    .coord     (coord_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  touch_coordinate_checker #(.COORD_BITS(COORD_BITS)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .touch       (touch_if),
    .coord       (coord_if),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .errors      (errors)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic void pick_window(output raw_t lo, output raw_t hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      lo = '0;
      hi = '1;
    end else if (r == 1) begin
      hi = raw_t'($urandom_range(0, 8191));
      lo = raw_t'($urandom_range(hi, 8191));
    end else begin
      lo = raw_t'($urandom_range(0, 6000));
      hi = raw_t'(lo + $urandom_range(1, 8191 - lo));
    end
  endfunction

  function automatic dim_t pick_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return dim_t'(1);
    end
    if (r == 1) begin
      return dim_t'(1024);
    end
    return dim_t'($urandom_range(1, 1024));
  endfunction

  // raw value around the window, a little outside on both sides
  function automatic raw_t near_window(input raw_t lo, input raw_t hi);
    int a, b;
    if (hi <= lo) begin
      return raw_t'($urandom_range(0, 8191));
    end
    a = int'(lo) - 64;
    b = int'(hi) + 64;
    if (a < 0) begin
      a = 0;
    end
    if (b > 8191) begin
      b = 8191;
    end
    return raw_t'($urandom_range(a, b));
  endfunction

  function automatic touch_sample_t random_sample(input mapper_cfg_t c);
    touch_sample_t s;
    s = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      {s.xh, s.xl[7:3]} = near_window(c.x_min, c.x_max);
      {s.yh, s.yl[7:3]} = near_window(c.y_min, c.y_max);
    end
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(input mapper_cfg_t c);
    write_reg(REG_CAL_X_MIN, c.x_min);
    write_reg(REG_CAL_X_MAX, c.x_max);
    write_reg(REG_CAL_Y_MIN, c.y_min);
    write_reg(REG_CAL_Y_MAX, c.y_max);
    write_reg(REG_ORIENTATION, CFG_DATA_W'(c.ori));
    write_reg(REG_PANEL_W, CFG_DATA_W'(c.pw));
    write_reg(REG_PANEL_H, CFG_DATA_W'(c.ph));
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input touch_sample_t s);
    int unsigned gap;
    touch_if.valid     <= 1'b1;
    touch_if.x_byte_hi <= s.xh;
    touch_if.x_byte_lo <= s.xl;
    touch_if.y_byte_hi <= s.yh;
    touch_if.y_byte_lo <= s.yl;
    @(posedge clk);
    while (!touch_if.ready) begin
      @(posedge clk);
    end
    gap = pick_gap(tx_quiet);
    if (gap != 0) begin
      touch_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender stops until every predicted beat has come back
  task automatic drain();
    touch_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int unsigned n;
    coord_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        coord_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = pick_gap(rx_quiet);
        if (n != 0) begin
          coord_if.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        coord_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    mapper_cfg_t c;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_CAL_X_MIN;
    cfg_data           <= '0;
    touch_if.valid     <= 1'b0;
    touch_if.x_byte_hi <= '0;
    touch_if.x_byte_lo <= '0;
    touch_if.y_byte_hi <= '0;
    touch_if.y_byte_lo <= '0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    hold_req = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset calibration: zero, above max, exactly max, just past max
    send_sample({8'h00, 8'h00, 8'h00, 8'h00});
    send_sample({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_sample({8'h7F, 8'hF8, 8'h7F, 8'hF8});
    send_sample({8'h80, 8'h00, 8'h80, 8'h00});
    send_sample({8'h00, 8'h07, 8'h00, 8'h07});
    send_sample({8'hAA, 8'h55, 8'h55, 8'hAA});
    drain();

    // full window, 1024 by 1024 panel, every orientation
    c.x_min = '0;
    c.x_max = '1;
    c.y_min = '0;
    c.y_max = '1;
    c.pw    = dim_t'(1024);
    c.ph    = dim_t'(1024);
    for (int o = 0; o < 4; o++) begin
      c.ori = orient_t'(o);
      apply_config(c);
      send_sample({8'h00, 8'h00, 8'hFF, 8'hFF});
      send_sample({8'hFF, 8'hFF, 8'h00, 8'h00});
      drain();
    end

    // empty X window, inverted Y window, single-pixel panel
    c.x_min = raw_t'(2000);
    c.x_max = raw_t'(2000);
    c.y_min = raw_t'(6000);
    c.y_max = raw_t'(10);
    c.ori   = ORI_INV_PORTRAIT;
    c.pw    = dim_t'(1);
    c.ph    = dim_t'(1);
    apply_config(c);
    send_sample({8'h3E, 8'h80, 8'hFF, 8'hFF});
    send_sample({8'h00, 8'h00, 8'h00, 8'h00});
    drain();

    // zero panel dimensions, mirrored
    c.x_min = '0;
    c.x_max = '1;
    c.y_min = '0;
    c.y_max = '1;
    c.ori   = ORI_LANDSCAPE;
    c.pw    = '0;
    c.ph    = '0;
    apply_config(c);
    send_sample({8'h80, 8'h00, 8'h80, 8'h00});
    send_sample({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      pick_window(c.x_min, c.x_max);
      pick_window(c.y_min, c.y_max);
      c.ori = orient_t'(p % 4);
      c.pw  = pick_dim();
      c.ph  = pick_dim();
      apply_config(c);
      tx_quiet = (p % 5 == 2);
      rx_quiet = (p % 5 == 4);
      if (p == 3) begin
        // back-pressure: output held off while beats keep coming
        tx_quiet = 1'b1;
        hold_req = 1'b1;
      end
      for (int k = 0; k < PHASE_BEATS; k++) begin
        send_sample(random_sample(c));
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
